// ===== hw/rtl/dlap_pkg.sv =====
// ----------------------------------------------------------------------------
// Delay-line allpass package
// Shared constants, command and status types and helper functions for the
// delay-line allpass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dlap_pkg;

    // Default depth of the circular delay line.
    localparam int DEPTH_DEFAULT = 4096;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int DL_W     = 12;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    // Multiplier operand and product widths.
    localparam int OPA_W  = 18;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_COEF  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DELAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN  = 2'd2;

    // Register reset values.
    localparam logic [COEF_W-1:0] COEF_RESET  = 16'd16384;
    localparam logic [DL_W-1:0]   DELAY_RESET = 12'd1;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;

    // Largest usable coefficient, 1.0 in Q1.15.
    localparam logic [COEF_W-1:0] COEF_MAX = 16'd32768;

    // Operand selection for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_AD = 2'd0,
        MUL_AV = 2'd1,
        MUL_WG = 2'd2
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     clr_write;
        logic     load_x;
        logic     red_step;
        logic     rd_en;
        logic     capture_d;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     write_v;
        logic     load_w;
        logic     load_out;
    } dlap_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic red_done;
    } dlap_status_t;

    // Number of shift-and-subtract steps that bring a delay below the depth.
    function automatic int reduce_steps(input int depth);
        int n;
        n = 0;
        for (int k = 0; k < DL_W; k++) begin
            if ((depth << k) <= ((1 << DL_W) - 1)) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    // Saturate a 20-bit signed value to a 16-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/delay_line_allpass_filter.sv =====
// ----------------------------------------------------------------------------
// Delay-line allpass filter
// Schroeder allpass on a circular delay line in Q1.15 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on in_valid/in_ready/sample_in and filtered samples
//   leave on out_valid/out_ready/sample_out; a request moves when valid and
//   ready are both high. Registers are written through cfg_write_en,
//   cfg_index and cfg_data; the user must do so only while the block is
//   idle, which the block itself does not enforce. Index 0 is the allpass
//   coefficient, 1 the delay length and 2 the makeup gain.
//   With a depth below 4096 a serial delay reduction runs after acceptance;
//   then the delay memory is read through its registered port, and one
//   shared 18x17 multiplier is used three times in sequence. A new sample
//   is accepted only once the previous one has reached the output register.
//   After reset the block clears the delay memory, one entry per cycle, and
//   holds in_ready low during that pass.
//   When the receiver stalls, the result waits in the output register; the
//   next sample is still accepted and computed, and it then waits for the
//   output register to drain before the block accepts another one.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_line_allpass_filter import dlap_pkg::*; #(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      sample_out
);

    dlap_cmd_t    cmd;
    dlap_status_t status;

    // Sequencer.
    dlap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, pointers and delay memory.
    dlap_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (sample_in),
        .sample_out   (sample_out),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dlap_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dlap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dlap_ctrl.sv =====
// ----------------------------------------------------------------------------
// Delay-line allpass controller
// Sequences the clearing pass, the delay read, the three multiplications
// and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dlap_ctrl import dlap_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire dlap_status_t status,
    output dlap_cmd_t         cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_SUBV  = 9'b000010000,
        S_MUL2  = 9'b000100000,
        S_SUMW  = 9'b001000000,
        S_MUL3  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new request when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_AD;
        in_ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.load_x = in_valid;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (status.red_done)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_MUL1;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_MUL1:
            begin
                cmd.capture_d = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_AD;
                state_next    = S_SUBV;
            end
            S_SUBV:
            begin
                cmd.write_v = 1'b1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AV;
                state_next  = S_SUMW;
            end
            S_SUMW:
            begin
                cmd.load_w = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WG;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dlap_datapath.sv =====
// ----------------------------------------------------------------------------
// Delay-line allpass datapath
// Configuration registers, delay-line pointers, the shared multiplier and
// the rounding and saturation logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dlap_datapath import dlap_pkg::*; #(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    input  wire dlap_cmd_t                  cmd,
    output dlap_status_t                    status
);

    localparam int AW        = $clog2(BUFFER_DEPTH);
    localparam int RED_STEPS = reduce_steps(BUFFER_DEPTH);
    localparam int PW        = (AW > DL_W) ? AW + 1 : DL_W + 1;

    // Configuration registers.
    logic [COEF_W-1:0] coef_reg;
    logic [DL_W-1:0]   dlen_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Sample state.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] d_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [OPA_W-1:0]    w_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    // Pointers.
    logic [DL_W-1:0] rem_reg;
    logic [DL_W-1:0] rem_step;
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   wp_next;
    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   rp_diff;

    // Memory ports.
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [SAMPLE_W-1:0] ram_wr_data;
    logic [SAMPLE_W-1:0] ram_rd_data;

    // Arithmetic.
    logic [COEF_W-1:0]          a_eff;
    logic signed [OPA_W-1:0]    op_a;
    logic signed [OPB_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   rnd15;
    logic signed [PROD_W-1:0]   rnd14;
    logic signed [OPA_W-1:0]    v_full;
    logic signed [SAMPLE_W-1:0] v_next;
    logic signed [OPA_W-1:0]    w_next;
    logic signed [SAMPLE_W-1:0] y_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
            dlen_reg <= DELAY_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_COEF:  coef_reg <= cfg_data[COEF_W-1:0];
                REG_DELAY: dlen_reg <= cfg_data[DL_W-1:0];
                REG_GAIN:  gain_reg <= cfg_data[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // Delay reduction modulo the depth, one shift-and-subtract step a cycle.
    generate
        if (RED_STEPS > 0)
        begin : g_red
            localparam int SW = $clog2(RED_STEPS + 1);
            localparam logic [DL_W-1:0] DEP_DL = DL_W'(BUFFER_DEPTH);

            logic [SW-1:0]   step_reg;
            logic [SW-1:0]   shift_amt;
            logic [DL_W-1:0] sub_val;

            assign shift_amt       = SW'(RED_STEPS - 1) - step_reg;
            assign sub_val         = DEP_DL << shift_amt;
            assign rem_step        = (rem_reg >= sub_val) ? rem_reg - sub_val : rem_reg;
            assign status.red_done = (step_reg == SW'(RED_STEPS));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else if (cmd.load_x)
                begin
                    step_reg <= '0;
                end
                else if (cmd.red_step)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
        else
        begin : g_nored
            assign rem_step        = rem_reg;
            assign status.red_done = 1'b1;
        end
    endgenerate

    // Read position: write position minus the delay, wrapped into the line.
    always_comb
    begin
        rp_diff = PW'(wp_reg) - PW'(rem_reg);
        if (PW'(wp_reg) < PW'(rem_reg))
        begin
            rp_diff = rp_diff + PW'(BUFFER_DEPTH);
        end
    end

    assign rd_addr = rp_diff[AW-1:0];
    assign wp_next = (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // Clearing pass status.
    assign status.clr_done = (clr_cnt_reg == AW'(BUFFER_DEPTH - 1));

    // Pointer and clearing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.write_v)
            begin
                wp_reg <= wp_next;
            end
            if (cmd.clr_write && !status.clr_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Shared multiplier operand selection.
    assign a_eff = (coef_reg > COEF_MAX) ? COEF_MAX : coef_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AD:
            begin
                op_a = {{2{ram_rd_data[SAMPLE_W-1]}}, ram_rd_data};
                op_b = $signed({1'b0, a_eff});
            end
            MUL_AV:
            begin
                op_a = {{2{v_reg[SAMPLE_W-1]}}, v_reg};
                op_b = $signed({1'b0, a_eff});
            end
            MUL_WG:
            begin
                op_a = w_reg;
                op_b = $signed({1'b0, gain_reg});
            end
            default:
            begin
                op_a = w_reg;
                op_b = $signed({1'b0, gain_reg});
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Rounding to nearest with ties upward, then saturation of v and the output.
    assign rnd15  = (prod_reg + 35'sd16384) >>> 15;
    assign rnd14  = (prod_reg + 35'sd8192) >>> 14;
    assign v_full = {{2{x_reg[SAMPLE_W-1]}}, x_reg} - rnd15[OPA_W-1:0];
    assign v_next = sat16({{2{v_full[OPA_W-1]}}, v_full});
    assign w_next = {{2{d_reg[SAMPLE_W-1]}}, d_reg} + rnd15[OPA_W-1:0];
    assign y_next = sat16(rnd14[19:0]);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg   <= sample_in;
            rem_reg <= dlen_reg;
        end
        else if (cmd.red_step)
        begin
            rem_reg <= rem_step;
        end
        if (cmd.capture_d)
        begin
            d_reg <= ram_rd_data;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.write_v)
        begin
            v_reg <= v_next;
        end
        if (cmd.load_w)
        begin
            w_reg <= w_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= y_next;
        end
    end

    assign sample_out = out_reg;

    // Memory write: zeros during the clearing pass, then the new v.
    assign ram_wr_en   = cmd.clr_write || cmd.write_v;
    assign ram_wr_addr = cmd.clr_write ? clr_cnt_reg : wp_reg;
    assign ram_wr_data = cmd.clr_write ? '0 : v_next;

    dlap_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
